// ===== design/json_string_unescape_utf8_assert.svh =====
// Assertion macros shared by the string unescaper modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define JSU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("jsu assertion failed");

// Check that a condition leads to a consequence in the next cycle.
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`else

`define JSU_ASSERT(lbl, clk, rstn, prop)
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/jsu_pkg.sv =====
// Shared types and codes of the JSON string unescaper.
package jsu_pkg;

    // Default depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] K_DATA  = 2'd0;
    localparam logic [1:0] K_DONE  = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNTERM   = 3'd1;
    localparam logic [2:0] E_CONTROL  = 3'd2;
    localparam logic [2:0] E_BAD_U    = 3'd3;
    localparam logic [2:0] E_BAD_ESC  = 3'd4;

    // One classified input byte: optional U+FFFD, optional code point, optional end
    typedef struct packed {
        logic        has_fffd;
        logic        has_cp;
        logic [1:0]  cp_last_idx;   // UTF-8 length of cp minus one (zero for a raw byte)
        logic [20:0] cp;
        logic        has_end;
        logic [1:0]  end_kind;
        logic [2:0]  end_err;
    } t_cmd;

endpackage

// ===== design/json_string_unescape_utf8.sv =====
// JSON string body unescaper with UTF-8 output: top level.
//
// Input stream: one raw byte of a JSON string body per transfer on s_axis
// (opening quote already removed). Output stream: decoded results on m_axis,
// tdata the UTF-8 byte, tuser the kind and error code, tlast on the final
// result caused by an input byte. A closing quote ends the string with kind
// "done"; NUL, control bytes, bad escapes and bad hex digits end it with kind
// "error", after which decoding restarts in plain content.
// Path: the first result of a byte passes through the command queue and then
// the emitter's command and state registers.
// Throughput: one input byte per cycle and one result per cycle. A byte that
// causes up to 6 results holds the output until all are sent; the
// command queue of QUEUE_DEPTH entries between classifier and emitter takes
// the slack, and s_axis_tready drops only while the queue is full.
// When the receiver stalls the current result is held and the queue fills,
// then input stalls. Reset clears the escape state, the queue and the output.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,     // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,     // [7:0] out_byte
    output logic [4:0] o_m_axis_tuser,     // [1:0] kind, [4:2] error_code
    output logic       o_m_axis_tlast      // last
);
    import jsu_pkg::*;

    logic full;
    logic push;
    logic pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd q_cmd;

    // Classify input bytes
    jsu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // Buffer commands
    jsu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (q_cmd),
        .o_valid (q_valid),
        .o_full  (full)
    );

    // Emit result bytes
    jsu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_pop       (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

// ===== design/jsu_fifo.sv =====
// Short command queue between the classifier and the byte emitter.
module jsu_fifo #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  jsu_pkg::t_cmd i_data,
    input  logic         i_pop,
    output jsu_pkg::t_cmd o_data,
    output logic         o_valid,
    output logic         o_full
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "json_string_unescape_utf8_assert.svh"
    `JSU_ASSERT(a_fifo_no_overrun, i_clk, i_rst_n, (i_push && !i_pop) |-> (r_count != FULL_CNT))
    `JSU_ASSERT(a_fifo_no_underrun, i_clk, i_rst_n, i_pop |-> (r_count != '0))
    `JSU_ASSERT(a_fifo_count_range, i_clk, i_rst_n, r_count <= FULL_CNT)

endmodule

// ===== design/jsu_front.sv =====
// Front end: accepts string bytes, runs the escape state machine, classifies results.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [7:0]    i_s_axis_tdata,
    input  logic          i_full,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        PH_PLAIN   = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_HEX     = 6'b000100,
        PH_HIGH    = 6'b001000,
        PH_HIGH_BS = 6'b010000,
        PH_HEX2    = 6'b100000
    } t_phase;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [20:0] CP_FFFD  = 21'h00FFFD;
    localparam logic [20:0] CP_PLANE1 = 21'h010000;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [11:0] r_acc, n_acc;
    logic [9:0]  r_pend, n_pend;

    logic [7:0]  c;
    logic        hv;
    logic [3:0]  h;
    logic        run_plain, run_esc, run_val;
    logic        raw_byte;
    logic [15:0] val;
    logic [15:0] hex_word;
    logic        accept;
    t_cmd        cmd;

    assign c = i_s_axis_tdata;
    assign o_s_axis_tready = !i_full;
    assign accept = i_s_axis_tvalid && !i_full;
    assign hex_word = {r_acc, h};

    // Decode one hex digit
    always_comb begin
        hv = 1'b0;
        h  = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            hv = 1'b1;
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hv = 1'b1;
            h  = c[3:0] + 4'd9;
        end
    end

    // Escape state machine and result classification
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_pend    = r_pend;
        cmd       = '0;
        run_plain = 1'b0;
        run_esc   = 1'b0;
        run_val   = 1'b0;
        raw_byte  = 1'b0;
        val       = hex_word;

        case (r_phase)
            PH_ESC: begin
                run_esc = 1'b1;
            end
            PH_HEX: begin
                if (!hv) begin
                    cmd.has_end  = 1'b1;
                    cmd.end_kind = K_ERROR;
                    cmd.end_err  = E_BAD_U;
                    n_phase      = PH_PLAIN;
                    n_cnt        = '0;
                end else if (r_cnt == 2'd3) begin
                    n_cnt   = '0;
                    run_val = 1'b1;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_acc = {r_acc[7:0], h};
                end
            end
            PH_HIGH: begin
                if (c == CH_BSLASH) begin
                    n_phase = PH_HIGH_BS;
                end else begin
                    cmd.has_fffd = 1'b1;
                    run_plain    = 1'b1;
                end
            end
            PH_HIGH_BS: begin
                if (c == CH_U) begin
                    n_phase = PH_HEX2;
                    n_acc   = '0;
                    n_cnt   = '0;
                end else begin
                    cmd.has_fffd = 1'b1;
                    run_esc      = 1'b1;
                end
            end
            PH_HEX2: begin
                if (!hv) begin
                    cmd.has_fffd = 1'b1;
                    cmd.has_end  = 1'b1;
                    cmd.end_kind = K_ERROR;
                    cmd.end_err  = E_BAD_U;
                    n_phase      = PH_PLAIN;
                    n_cnt        = '0;
                end else if (r_cnt == 2'd3) begin
                    n_cnt = '0;
                    if (hex_word[15:10] == 6'b110111) begin
                        // Join the surrogate pair
                        cmd.has_cp = 1'b1;
                        cmd.cp     = CP_PLANE1 + {1'b0, r_pend, hex_word[9:0]};
                        n_phase    = PH_PLAIN;
                    end else begin
                        cmd.has_fffd = 1'b1;
                        run_val      = 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 2'd1;
                    n_acc = {r_acc[7:0], h};
                end
            end
            default: begin
                run_plain = 1'b1;
            end
        endcase

        // Plain string content
        if (run_plain) begin
            n_phase = PH_PLAIN;
            if (c == 8'h00) begin
                cmd.has_end  = 1'b1;
                cmd.end_kind = K_ERROR;
                cmd.end_err  = E_UNTERM;
                n_cnt        = '0;
            end else if (c == CH_QUOTE) begin
                cmd.has_end  = 1'b1;
                cmd.end_kind = K_DONE;
                cmd.end_err  = E_NONE;
                n_cnt        = '0;
            end else if (c < CH_SPACE) begin
                cmd.has_end  = 1'b1;
                cmd.end_kind = K_ERROR;
                cmd.end_err  = E_CONTROL;
                n_cnt        = '0;
            end else if (c == CH_BSLASH) begin
                n_phase = PH_ESC;
            end else begin
                // Pass the raw byte through as a single result, even above 0x7F
                cmd.has_cp = 1'b1;
                cmd.cp     = {13'd0, c};
                raw_byte   = 1'b1;
            end
        end

        // Character after a backslash
        if (run_esc) begin
            n_phase    = PH_PLAIN;
            cmd.has_cp = 1'b1;
            case (c)
                CH_QUOTE:  cmd.cp = {13'd0, CH_QUOTE};
                CH_BSLASH: cmd.cp = {13'd0, CH_BSLASH};
                CH_SLASH:  cmd.cp = {13'd0, CH_SLASH};
                CH_B:      cmd.cp = 21'h08;
                CH_F:      cmd.cp = 21'h0C;
                CH_N:      cmd.cp = 21'h0A;
                CH_R:      cmd.cp = 21'h0D;
                CH_T:      cmd.cp = 21'h09;
                CH_U: begin
                    cmd.has_cp = 1'b0;
                    n_phase    = PH_HEX;
                    n_acc      = '0;
                    n_cnt      = '0;
                end
                default: begin
                    cmd.has_cp   = 1'b0;
                    cmd.has_end  = 1'b1;
                    cmd.end_kind = K_ERROR;
                    cmd.end_err  = E_BAD_ESC;
                    n_cnt        = '0;
                end
            endcase
        end

        // Completed escape value on its own
        if (run_val) begin
            n_phase = PH_PLAIN;
            if (val[15:10] == 6'b110110) begin
                n_pend  = val[9:0];
                n_phase = PH_HIGH;
            end else if (val[15:11] == 5'b11011) begin
                cmd.has_cp = 1'b1;
                cmd.cp     = CP_FFFD;
            end else begin
                cmd.has_cp = 1'b1;
                cmd.cp     = {5'd0, val};
            end
        end

        // UTF-8 length of the code point; a raw byte is always one result
        if (raw_byte) begin
            cmd.cp_last_idx = 2'd0;
        end else if (cmd.cp[20:16] != '0) begin
            cmd.cp_last_idx = 2'd3;
        end else if (cmd.cp[15:11] != '0) begin
            cmd.cp_last_idx = 2'd2;
        end else if (cmd.cp[10:7] != '0) begin
            cmd.cp_last_idx = 2'd1;
        end else begin
            cmd.cp_last_idx = 2'd0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.has_fffd || cmd.has_cp || cmd.has_end);

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_cnt   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Hold hex value and pending high surrogate
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== design/jsu_back.sv =====
// Back end: expands queued commands into UTF-8 bytes and end markers.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [7:0]    o_m_axis_tdata,
    output logic [4:0]    o_m_axis_tuser,
    output logic          o_m_axis_tlast
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FFFD = 4'b0010,
        S_CP   = 4'b0100,
        S_END  = 4'b1000
    } t_bstate;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    t_bstate    r_state, n_state;
    logic [1:0] r_idx, n_idx;
    t_cmd       r_cmd;

    logic       last;
    logic       xfer;
    logic       load;
    logic [1:0] kind;
    logic [2:0] err;

    // Byte idx of the UTF-8 form of cp, whose last byte index is li
    function automatic logic [7:0] f_utf8(logic [20:0] cp, logic [1:0] li, logic [1:0] idx);
        logic [1:0] k;
        logic [7:0] b;
        k = li - idx;
        b = 8'h00;
        if (idx == 2'd0) begin
            case (li)
                2'd0:    b = cp[7:0];
                2'd1:    b = UTF8_LEAD2 | {3'd0, cp[10:6]};
                2'd2:    b = UTF8_LEAD3 | {4'd0, cp[15:12]};
                default: b = UTF8_LEAD4 | {5'd0, cp[20:18]};
            endcase
        end else begin
            case (k)
                2'd0:    b = UTF8_CONT | {2'd0, cp[5:0]};
                2'd1:    b = UTF8_CONT | {2'd0, cp[11:6]};
                default: b = UTF8_CONT | {2'd0, cp[17:12]};
            endcase
        end
        return b;
    endfunction

    // Drive the current result
    always_comb begin
        o_m_axis_tvalid = 1'b1;
        o_m_axis_tdata  = 8'h00;
        kind            = K_DATA;
        err             = E_NONE;
        last            = 1'b0;
        case (r_state)
            S_FFFD: begin
                case (r_idx)
                    2'd0:    o_m_axis_tdata = 8'hEF;
                    2'd1:    o_m_axis_tdata = 8'hBF;
                    default: o_m_axis_tdata = 8'hBD;
                endcase
                last = (r_idx == 2'd2) && !r_cmd.has_cp && !r_cmd.has_end;
            end
            S_CP: begin
                o_m_axis_tdata = f_utf8(r_cmd.cp, r_cmd.cp_last_idx, r_idx);
                last = (r_idx == r_cmd.cp_last_idx) && !r_cmd.has_end;
            end
            S_END: begin
                kind = r_cmd.end_kind;
                err  = r_cmd.end_err;
                last = 1'b1;
            end
            default: begin
                o_m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign o_m_axis_tuser = {err, kind};
    assign o_m_axis_tlast = last;

    assign xfer      = o_m_axis_tvalid && i_m_axis_tready;
    assign load      = (r_state == S_IDLE) || (xfer && last);
    assign o_cmd_pop = load && i_cmd_valid;

    // Advance through the bytes of a command
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (load) begin
            n_idx = '0;
            if (!i_cmd_valid) begin
                n_state = S_IDLE;
            end else if (i_cmd.has_fffd) begin
                n_state = S_FFFD;
            end else if (i_cmd.has_cp) begin
                n_state = S_CP;
            end else begin
                n_state = S_END;
            end
        end else if (xfer) begin
            case (r_state)
                S_FFFD: begin
                    if (r_idx == 2'd2) begin
                        n_idx   = '0;
                        n_state = r_cmd.has_cp ? S_CP : S_END;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                S_CP: begin
                    if (r_idx == r_cmd.cp_last_idx) begin
                        n_idx   = '0;
                        n_state = S_END;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // Hold emitter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Take the next command
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

`include "json_string_unescape_utf8_assert.svh"
    `JSU_ASSERT(a_back_end_last, i_clk, i_rst_n, (o_m_axis_tvalid && (kind != K_DATA)) |-> o_m_axis_tlast)
    `JSU_ASSERT(a_back_pop_on_last, i_clk, i_rst_n, (o_cmd_pop && o_m_axis_tvalid) |-> (i_m_axis_tready && o_m_axis_tlast))
    `JSU_ASSERT_NEXT(a_back_go_idle, i_clk, i_rst_n, (xfer && last && !i_cmd_valid), !o_m_axis_tvalid)

endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
// Stream test of the JSON string unescaper against a byte-level decoder model.
`timescale 1ns / 1ps

module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 410;
    localparam int CALM_ITEMS     = 60;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_U      = 8'h75;
    localparam logic [63:0] ESC_SET   = "\"\\/bfnrt";
    localparam logic [20:0] CP_REPLACEMENT = 21'hFFFD;

    typedef enum logic [3:0] {
        ST_TEXT,
        ST_BACKSLASH,
        ST_HEX,
        ST_HIGH_WAIT,
        ST_HIGH_BACKSLASH,
        ST_LOW_HEX
    } t_decode_state;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic [2:0] err;
        logic       last;
    } t_utf8_result;

    typedef struct packed {
        logic [7:0] data;
        logic       hold;   // wait for all decoded output before sending
        logic       calm;   // no idling from this byte on
    } t_text_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;           // [7:0] out_byte
    logic [4:0] o_m_axis_tuser;           // [1:0] kind, [4:2] error_code
    logic       o_m_axis_tlast;

    json_string_unescape_utf8 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_text_byte   text_q[$];
    t_utf8_result decoded_q[$];
    t_utf8_result byte_results[$];
    t_text_byte   next_byte;
    logic         gen_hold = 1'b0;
    logic         gen_calm = 1'b0;
    logic         rx_calm = 1'b0;
    logic         s_fire = 1'b0;
    int           s_gap = 0;
    int           r_gap = 0;
    int           sent_count = 0;
    int           text_total = 0;
    int           fail_count = 0;
    int           idle_cycles = 0;

    // Decoder model state
    t_decode_state dec_state = ST_TEXT;
    logic [15:0]   hex_value = 16'h0000;
    logic [2:0]    hex_digits = 3'd0;
    logic [15:0]   high_half = 16'h0000;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);   // {ok, value}
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic [1:0] k, input logic [2:0] e);
        t_utf8_result r;
        r.data = b;
        r.kind = k;
        r.err  = e;
        r.last = 1'b0;
        byte_results.push_back(r);
    endtask

    // Emit the end marker and restart in plain text
    task automatic close_string(input logic [1:0] k, input logic [2:0] e);
        add_result(8'h00, k, e);
        dec_state  = ST_TEXT;
        hex_value  = 16'h0000;
        hex_digits = 3'd0;
        high_half  = 16'h0000;
    endtask

    task automatic encode_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_result(cp[7:0], K_DATA, E_NONE);
        end else if (cp < 21'h800) begin
            add_result({3'b110, cp[10:6]}, K_DATA, E_NONE);
            add_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else if (cp < 21'h10000) begin
            add_result({4'b1110, cp[15:12]}, K_DATA, E_NONE);
            add_result({2'b10, cp[11:6]}, K_DATA, E_NONE);
            add_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end else begin
            add_result({5'b11110, cp[20:18]}, K_DATA, E_NONE);
            add_result({2'b10, cp[17:12]}, K_DATA, E_NONE);
            add_result({2'b10, cp[11:6]}, K_DATA, E_NONE);
            add_result({2'b10, cp[5:0]}, K_DATA, E_NONE);
        end
    endtask

    task automatic text_char(input logic [7:0] c);
        dec_state = ST_TEXT;
        if (c == 8'h00) begin
            close_string(K_ERROR, E_UNTERM);
        end else if (c == CH_QUOTE) begin
            close_string(K_DONE, E_NONE);
        end else if (c < 8'h20) begin
            close_string(K_ERROR, E_CONTROL);
        end else if (c == CH_BSLASH) begin
            dec_state = ST_BACKSLASH;
        end else begin
            add_result(c, K_DATA, E_NONE);
        end
    endtask

    task automatic escape_char(input logic [7:0] c);
        dec_state = ST_TEXT;
        case (c)
            CH_QUOTE, CH_BSLASH, "/": add_result(c, K_DATA, E_NONE);
            "b": add_result(8'h08, K_DATA, E_NONE);
            "f": add_result(8'h0C, K_DATA, E_NONE);
            "n": add_result(8'h0A, K_DATA, E_NONE);
            "r": add_result(8'h0D, K_DATA, E_NONE);
            "t": add_result(8'h09, K_DATA, E_NONE);
            CH_U: begin
                dec_state  = ST_HEX;
                hex_value  = 16'h0000;
                hex_digits = 3'd0;
            end
            default: close_string(K_ERROR, E_BAD_ESC);
        endcase
    endtask

    // Decode one complete \u value that is not the second half of a pair
    task automatic single_value(input logic [15:0] v);
        dec_state = ST_TEXT;
        if (v >= 16'hD800 && v < 16'hDC00) begin
            high_half = v;
            dec_state = ST_HIGH_WAIT;
        end else if (v >= 16'hD800 && v < 16'hE000) begin
            encode_utf8(CP_REPLACEMENT);
        end else begin
            encode_utf8({5'd0, v});
        end
    endtask

    task automatic take_hex(input logic [7:0] c, output bit ok);
        logic [4:0] h;
        h  = hex_nibble(c);
        ok = h[4];
        if (ok) begin
            hex_value  = {hex_value[11:0], h[3:0]};
            hex_digits = hex_digits + 3'd1;
        end
    endtask

    // Advance the model by one input byte and queue what it yields
    task automatic decode_byte(input logic [7:0] c);
        bit           ok;
        t_utf8_result r;
        byte_results.delete();
        case (dec_state)
            ST_BACKSLASH: escape_char(c);
            ST_HEX: begin
                take_hex(c, ok);
                if (!ok) begin
                    close_string(K_ERROR, E_BAD_U);
                end else if (hex_digits >= 3'd4) begin
                    hex_digits = 3'd0;
                    single_value(hex_value);
                end
            end
            ST_HIGH_WAIT: begin
                if (c == CH_BSLASH) begin
                    dec_state = ST_HIGH_BACKSLASH;
                end else begin
                    encode_utf8(CP_REPLACEMENT);
                    high_half = 16'h0000;
                    text_char(c);
                end
            end
            ST_HIGH_BACKSLASH: begin
                if (c == CH_U) begin
                    dec_state  = ST_LOW_HEX;
                    hex_value  = 16'h0000;
                    hex_digits = 3'd0;
                end else begin
                    encode_utf8(CP_REPLACEMENT);
                    high_half = 16'h0000;
                    escape_char(c);
                end
            end
            ST_LOW_HEX: begin
                take_hex(c, ok);
                if (!ok) begin
                    encode_utf8(CP_REPLACEMENT);
                    close_string(K_ERROR, E_BAD_U);
                end else if (hex_digits >= 3'd4) begin
                    hex_digits = 3'd0;
                    if (hex_value >= 16'hDC00 && hex_value < 16'hE000) begin
                        encode_utf8(21'h10000 + {1'b0, high_half[9:0], hex_value[9:0]});
                        high_half = 16'h0000;
                        dec_state = ST_TEXT;
                    end else begin
                        encode_utf8(CP_REPLACEMENT);
                        high_half = 16'h0000;
                        single_value(hex_value);
                    end
                end
            end
            default: text_char(c);
        endcase
        for (int i = 0; i < byte_results.size(); i++) begin
            r = byte_results[i];
            r.last = (i == byte_results.size() - 1);
            decoded_q.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus helpers
    task automatic queue_byte(input logic [7:0] b);
        t_text_byte t;
        t.data = b;
        t.hold = gen_hold;
        t.calm = gen_calm;
        text_q.push_back(t);
        gen_hold = 1'b0;
    endtask

    task automatic queue_hex_digit(input logic [3:0] n);
        if (n < 4'd10)
            queue_byte("0" + n);
        else if ($urandom_range(0, 1) != 0)
            queue_byte("a" + n - 8'd10);
        else
            queue_byte("A" + n - 8'd10);
    endtask

    task automatic queue_u_escape(input logic [15:0] v);
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            queue_hex_digit(v[4*i +: 4]);
    endtask

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        logic [4:0] h;
        do begin
            b = 8'($urandom_range(0, 255));
            h = hex_nibble(b);
        end while (h[4]);
        return b;
    endfunction

    // Escape opener, a few digits, then a byte that is no hex digit
    task automatic queue_bad_u();
        int n;
        n = $urandom_range(0, 3);
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        for (int i = 0; i < n; i++)
            queue_hex_digit(4'($urandom_range(0, 15)));
        queue_byte(non_hex_byte());
    endtask

    function automatic bit is_escape_char(input logic [7:0] b);
        for (int i = 0; i < 8; i++)
            if (ESC_SET[8*i +: 8] == b)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [15:0] random_scalar();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    // Send string bytes, with random gaps and the one drain pause
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_axis_tvalid && !s_fire)) begin
            if (text_q.size() != 0)
                next_byte = text_q[0];
            if (s_gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (text_q.size() == 0 || (next_byte.hold && decoded_q.size() != 0)) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (!next_byte.calm && $urandom_range(0, 5) == 0) begin
                i_s_axis_tvalid <= 1'b0;
                s_gap <= $urandom_range(0, 3);
            end else begin
                next_byte = text_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= next_byte.data;
                rx_calm         <= next_byte.calm;
            end
        end
    end

    // Stall the output side in short bursts
    always @(negedge i_clk) begin
        if (r_gap != 0) begin
            i_m_axis_tready <= 1'b0;
            r_gap <= r_gap - 1;
        end else if (!rx_calm && i_m_axis_tready && $urandom_range(0, 4) == 0) begin
            i_m_axis_tready <= 1'b0;
            r_gap <= $urandom_range(0, 3);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decode_byte(i_s_axis_tdata);
                sent_count <= sent_count + 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("result with no expectation: tdata %0h tuser %0h tlast %0b",
                           o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                    fail_count++;
                end else begin
                    compare_field("out_byte", decoded_q[0].data, o_m_axis_tdata);
                    compare_field("kind", 8'(decoded_q[0].kind), 8'(o_m_axis_tuser[1:0]));
                    compare_field("error_code", 8'(decoded_q[0].err),
                                  8'(o_m_axis_tuser[4:2]));
                    compare_field("last", 8'(decoded_q[0].last), 8'(o_m_axis_tlast));
                    void'(decoded_q.pop_front());
                end
            end
        end
        s_fire <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stop a run that no longer moves
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [7:0] b;
        int         directed_n;

        // Directed: pair for U+1F600, high surrogate closed by a quote
        queue_u_escape(16'hD83D);
        queue_u_escape(16'hDE00);
        queue_u_escape(16'hDBFF);
        queue_byte(CH_QUOTE);
        // NUL as the escape character, control byte, NUL, field extremes
        queue_byte(CH_BSLASH);
        queue_byte(8'h00);
        queue_byte(8'h1F);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h20);
        queue_byte(CH_QUOTE);
        directed_n = text_q.size();

        // Random strings: mostly well-formed tokens, some broken ones and noise
        gen_hold = 1'b1;
        while (text_q.size() < directed_n + RANDOM_ITEMS) begin
            if (text_q.size() >= directed_n + RANDOM_ITEMS - CALM_ITEMS)
                gen_calm = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3: queue_byte(8'($urandom_range(8'h20, 8'hFF)));
                4, 5: begin
                    queue_byte(CH_BSLASH);
                    queue_byte(ESC_SET[8*$urandom_range(0, 7) +: 8]);
                end
                6, 7, 8: queue_u_escape(random_scalar());
                9: queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                10, 11, 12: begin
                    queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                    case ($urandom_range(0, 7))
                        0, 1, 2: queue_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                        3: begin
                            if ($urandom_range(0, 1) != 0)
                                queue_u_escape(random_scalar());
                            else
                                queue_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
                        end
                        4: begin
                            queue_byte(CH_BSLASH);
                            if ($urandom_range(0, 1) != 0)
                                queue_byte(ESC_SET[8*$urandom_range(0, 7) +: 8]);
                            else
                                queue_byte(8'($urandom_range(0, 255)));
                        end
                        5: queue_byte(8'($urandom_range(0, 255)));
                        6: queue_bad_u();
                        default: ;
                    endcase
                end
                13: begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (is_escape_char(b) || b == CH_U);
                    queue_byte(CH_BSLASH);
                    queue_byte(b);
                end
                14: queue_bad_u();
                15, 16: queue_byte(CH_QUOTE);
                17: queue_byte(8'($urandom_range(0, 8'h1F)));
                default: queue_byte(8'($urandom_range(0, 255)));
            endcase
        end
        text_total = text_q.size();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken and every result to arrive
        do
            @(negedge i_clk);
        while (sent_count != text_total || decoded_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
